/* hw/rtl/line_edit_key_ring_buffer_macros.svh */
// Assertion helpers used by the ring buffer controller.
`ifndef LINE_EDIT_KEY_RING_BUFFER_MACROS_SVH
`define LINE_EDIT_KEY_RING_BUFFER_MACROS_SVH

// Plain property check, sampled on the rising clock edge and disabled in reset.
`define LEKRB_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in this cycle implies the consequent in the next one.
`define LEKRB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    `LEKRB_ASSERT(label, clk, rstn, (ante) |=> (cons), msg)

`endif

/* hw/rtl/lekrb_pkg.sv */
`default_nettype none

package lekrb_pkg;

    // Field widths of the two channels.
    localparam int KIND_W     = 2;
    localparam int KEY_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int ENTRY_W    = 9;
    localparam int S_TDATA_W  = 8;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 24;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NODEL   = 3'd4;

    localparam logic [KEY_W-1:0] KEY_NEWLINE = 8'd10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the beat and issue the store read
        logic commit;  // update state and load the result register
    } ctrl_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/lekrb_ctrl.sv */
`default_nettype none

`include "line_edit_key_ring_buffer_macros.svh"

module lekrb_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output lekrb_pkg::ctrl_cmd_t       cmd
);
    import lekrb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign cmd.load   = s_tvalid && s_tready;
    assign cmd.commit = (state_reg == S_EXEC) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.load) state_next = S_EXEC;
            end
            S_EXEC: begin
                // The result waits here until the output register can take it.
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `LEKRB_ASSERT(a_state_onehot, aclk, aresetn, $onehot(state_reg), "state not one-hot")
    `LEKRB_ASSERT_NEXT(a_load_exec, aclk, aresetn, cmd.load, state_reg == S_EXEC, "load did not start execution")
    `LEKRB_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, (state_reg == S_EXEC) && m_tvalid_reg && !m_tready, state_reg == S_EXEC, "result dropped while output stalled")
    `LEKRB_ASSERT_NEXT(a_commit_out, aclk, aresetn, cmd.commit, m_tvalid_reg && (state_reg == S_IDLE), "commit did not present a result")

endmodule

`default_nettype wire

/* hw/rtl/lekrb_dp.sv */
`default_nettype none

module lekrb_dp #(
    parameter int DEPTH = 256
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire lekrb_pkg::ctrl_cmd_t                 cmd,
    input  wire logic [lekrb_pkg::KIND_W-1:0]         in_kind,
    input  wire logic                                 in_printable,
    input  wire logic [lekrb_pkg::KEY_W-1:0]          in_key_value,
    output logic [lekrb_pkg::STATUS_W-1:0]            out_status,
    output logic [lekrb_pkg::KEY_W-1:0]               out_read_char,
    output logic                                      out_line_ready,
    output logic [lekrb_pkg::ENTRY_W-1:0]             out_entry_count
);
    import lekrb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

    logic [KEY_W-1:0] char_store_mem [DEPTH];

    logic [KIND_W-1:0]   kind_reg;
    logic                printable_reg;
    logic [KEY_W-1:0]    key_value_reg;
    logic [KEY_W-1:0]    rd_data_reg;

    logic [AW-1:0] insert_ptr_reg, insert_ptr_next;
    logic [AW-1:0] last_rd_ptr_reg, last_rd_ptr_next;
    logic [CW-1:0] newline_cnt_reg, newline_cnt_next;
    logic [CW-1:0] held_cnt_reg, held_cnt_next;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic [KEY_W-1:0]    read_char_reg, read_char_next;
    logic                line_ready_reg;
    logic [ENTRY_W-1:0]  entry_count_reg;

    logic [AW-1:0] rd_next_ptr, ins_prev_ptr, rd_addr;
    logic          wr_en;

    assign rd_next_ptr  = (last_rd_ptr_reg == PTR_LAST) ? '0 : AW'(last_rd_ptr_reg + 1'b1);
    assign ins_prev_ptr = (insert_ptr_reg == '0) ? PTR_LAST : AW'(insert_ptr_reg - 1'b1);
    // A read looks at the oldest slot, a delete at the newest one.
    assign rd_addr = (in_kind == KIND_READ) ? rd_next_ptr : ins_prev_ptr;

    always_comb begin
        status_next      = STAT_OK;
        read_char_next   = '0;
        insert_ptr_next  = insert_ptr_reg;
        last_rd_ptr_next = last_rd_ptr_reg;
        newline_cnt_next = newline_cnt_reg;
        held_cnt_next    = held_cnt_reg;
        wr_en            = 1'b0;
        unique case (kind_reg)
            KIND_WRITE: begin
                // Fullness is judged before the key type; one slot is kept for a newline.
                priority if (held_cnt_reg >= CW'(DEPTH - 1)) begin
                    status_next = STAT_FULL;
                end else if (held_cnt_reg == CW'(DEPTH - 2) && key_value_reg != KEY_NEWLINE) begin
                    status_next = STAT_FULL;
                end else if (!printable_reg) begin
                    status_next = STAT_INVALID;
                end else begin
                    wr_en           = 1'b1;
                    insert_ptr_next = (insert_ptr_reg == PTR_LAST) ? '0
                                                                   : AW'(insert_ptr_reg + 1'b1);
                    held_cnt_next   = CW'(held_cnt_reg + 1'b1);
                    if (key_value_reg == KEY_NEWLINE) begin
                        newline_cnt_next = CW'(newline_cnt_reg + 1'b1);
                    end
                end
            end
            KIND_READ: begin
                if (held_cnt_reg == '0 || rd_next_ptr == insert_ptr_reg) begin
                    status_next = STAT_EMPTY;
                end else begin
                    read_char_next   = rd_data_reg;
                    last_rd_ptr_next = rd_next_ptr;
                    held_cnt_next    = CW'(held_cnt_reg - 1'b1);
                    if (rd_data_reg == KEY_NEWLINE && newline_cnt_reg != '0) begin
                        newline_cnt_next = CW'(newline_cnt_reg - 1'b1);
                    end
                end
            end
            KIND_DELETE: begin
                // A completed line cannot be edited back into.
                priority if (held_cnt_reg == '0 || ins_prev_ptr == last_rd_ptr_reg) begin
                    status_next = STAT_NODEL;
                end else if (rd_data_reg == KEY_NEWLINE) begin
                    status_next = STAT_NODEL;
                end else begin
                    insert_ptr_next = ins_prev_ptr;
                    held_cnt_next   = CW'(held_cnt_reg - 1'b1);
                end
            end
            default: begin
                status_next = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && wr_en) begin
            char_store_mem[insert_ptr_reg] <= key_value_reg;
        end
        if (cmd.load) begin
            rd_data_reg <= char_store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg      <= in_kind;
            printable_reg <= in_printable;
            key_value_reg <= in_key_value;
        end
        if (cmd.commit) begin
            status_reg      <= status_next;
            read_char_reg   <= read_char_next;
            line_ready_reg  <= (newline_cnt_next != '0);
            entry_count_reg <= ENTRY_W'(held_cnt_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            insert_ptr_reg  <= '0;
            last_rd_ptr_reg <= PTR_LAST;
            newline_cnt_reg <= '0;
            held_cnt_reg    <= '0;
        end else if (cmd.commit) begin
            insert_ptr_reg  <= insert_ptr_next;
            last_rd_ptr_reg <= last_rd_ptr_next;
            newline_cnt_reg <= newline_cnt_next;
            held_cnt_reg    <= held_cnt_next;
        end
    end

    assign out_status      = status_reg;
    assign out_read_char   = read_char_reg;
    assign out_line_ready  = line_ready_reg;
    assign out_entry_count = entry_count_reg;

endmodule

`default_nettype wire

/* hw/rtl/line_edit_key_ring_buffer.sv */
// Channel | Dir | Beat contents (lowest bit first)
// s_      | in  | tdata: key_value[7:0]; tuser: kind[1:0], key_printable[2]
// m_      | out | tdata: status[2:0], read_char[10:3], line_ready[11],
//         |     |        entry_count[20:12], zero pad [23:21]
//
// Each beat is first registered while the character store is read, then the
// pointers and counts are updated and the result register is loaded. A new
// beat is not accepted until the last one has been committed.
// A result left waiting on m_ holds the next beat's update until it is taken, but a
// new beat is accepted while it waits. Reset is synchronous, needs no
// clearing pass, and empties the buffer at once.
`default_nettype none

module line_edit_key_ring_buffer #(
    parameter int DEPTH = 256
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [lekrb_pkg::S_TDATA_W-1:0]   s_tdata,   // key_value
    input  wire logic [lekrb_pkg::S_TUSER_W-1:0]   s_tuser,   // kind, key_printable
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [lekrb_pkg::M_TDATA_W-1:0]        m_tdata    // status, read_char,
                                                              // line_ready, entry_count
);
    import lekrb_pkg::*;

    ctrl_cmd_t           cmd;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    read_char;
    logic                line_ready;
    logic [ENTRY_W-1:0]  entry_count;

    lekrb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lekrb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .in_kind         (s_tuser[KIND_W-1:0]),
        .in_printable    (s_tuser[KIND_W]),
        .in_key_value    (s_tdata[KEY_W-1:0]),
        .out_status      (status),
        .out_read_char   (read_char),
        .out_line_ready  (line_ready),
        .out_entry_count (entry_count)
    );

    assign m_tdata = {3'b000, entry_count, line_ready, read_char, status};

endmodule

`default_nettype wire
